// ===== rtl/weighted_histogram_accumulator_defines.svh =====
// Assertion macros for the weighted histogram accumulator.
// Included by the top level; expects a clock named clk and a reset named rst.
`ifndef WEIGHTED_HISTOGRAM_ACCUMULATOR_DEFINES_SVH
`define WEIGHTED_HISTOGRAM_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define WHA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define WHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/wha_pkg.sv =====
// Shared types, codes and helper functions for the weighted histogram accumulator.
// Used by the top level; has no dependencies.
package wha_pkg;

  localparam int DefNumBins       = 64;
  localparam int DefNumWeightSets = 4;
  localparam int KindCount        = 7;

  localparam logic [2:0] KIND_COUNT  = 3'd0;
  localparam logic [2:0] KIND_SUMW   = 3'd1;
  localparam logic [2:0] KIND_SUMWW  = 3'd2;
  localparam logic [2:0] KIND_SUMXW  = 3'd3;
  localparam logic [2:0] KIND_SUMXXW = 3'd4;
  localparam logic [2:0] KIND_UNDER  = 3'd5;
  localparam logic [2:0] KIND_OVER   = 3'd6;
  localparam logic [2:0] KIND_BIN    = 3'd7;

  localparam logic [1:0] REG_RANGE_LOW  = 2'd0;
  localparam logic [1:0] REG_RANGE_HIGH = 2'd1;
  localparam logic [1:0] REG_INV_WIDTH  = 2'd2;

  localparam logic [1:0] REGION_UNDER = 2'd0;
  localparam logic [1:0] REGION_IN    = 2'd1;
  localparam logic [1:0] REGION_OVER  = 2'd2;
  localparam logic [1:0] REGION_READ  = 2'd3;

  localparam logic CMD_FILL = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef logic signed [63:0] acc_t;

  // Signed 64-bit addition that clamps at the int64 limits.
  function automatic acc_t sat_add(acc_t a, acc_t b);
    acc_t s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s;
  endfunction

endpackage

// ===== rtl/weighted_histogram_accumulator.sv =====
// Weighted histogram accumulator: input and result channels, APB register port.
// Depends on wha_pkg, wha_ram and weighted_histogram_accumulator_defines.svh.
//
// A fill beat (cmd 0) adds one to the count and |sample_weight| terms into the
// sum, sum-of-squares, value-weighted sums and one of underflow, overflow or a
// bin of the chosen weight set; the weight's sign picks the positive or negative
// side. A read beat (cmd 1) returns one accumulator on read_data.
// Every input beat produces exactly one result beat. A fill passes through
// three multiply stages, then an update sweep that streams the seven
// statistics words through the statistics RAM, one read and one write-back
// per cycle. A read goes through a RAM read state. One item is in flight at a time;
// in_stall is low again once the result sits in the output register, so a new
// item is taken while that result waits for the receiver.
// If the receiver stalls, the result holds and a finished item waits for the
// output register to free up.
// After reset both RAMs are zeroed by a clear pass over
// max(2*NUM_BINS*NUM_WEIGHT_SETS, 14*NUM_WEIGHT_SETS) addresses (512 with the
// defaults), during which in_stall is high; register writes are taken throughout.
module weighted_histogram_accumulator
  import wha_pkg::*;
#(
  parameter int NUM_BINS        = DefNumBins,
  parameter int NUM_WEIGHT_SETS = DefNumWeightSets
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  logic signed [31:0] sample_value,
  input  logic signed [31:0] sample_weight,
  input  logic [1:0]         weight_set,
  input  logic [2:0]         read_kind,
  input  logic [5:0]         read_bin,
  input  logic               read_negative_side,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] read_data,
  output logic [1:0]         fill_region,
  output logic [5:0]         fill_bin
);

  localparam int BinDepth  = NUM_BINS * NUM_WEIGHT_SETS * 2;
  localparam int StatDepth = KindCount * NUM_WEIGHT_SETS * 2;
  localparam int BinAw     = (BinDepth > 1) ? $clog2(BinDepth) : 1;
  localparam int StatAw    = (StatDepth > 1) ? $clog2(StatDepth) : 1;
  localparam int BinW      = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int ClrDepth  = (BinDepth > StatDepth) ? BinDepth : StatDepth;
  localparam int ClrW      = $clog2(ClrDepth + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_MUL1  = 3'd2;
  localparam logic [2:0] S_MUL2  = 3'd3;
  localparam logic [2:0] S_MUL3  = 3'd4;
  localparam logic [2:0] S_UPD   = 3'd5;
  localparam logic [2:0] S_RD    = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  // Configuration registers.
  logic [31:0] range_low, range_high, inverse_bin_width;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_low         <= 32'd0;
      range_high        <= 32'd4194304;
      inverse_bin_width <= 32'd65536;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_RANGE_LOW:  range_low         <= pwdata;
        REG_RANGE_HIGH: range_high        <= pwdata;
        REG_INV_WIDTH:  inverse_bin_width <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_RANGE_LOW:  prdata = range_low;
      REG_RANGE_HIGH: prdata = range_high;
      REG_INV_WIDTH:  prdata = inverse_bin_width;
      default:        prdata = 32'd0;
    endcase
  end

  // Control state.
  logic [2:0]      state;
  logic [ClrW-1:0] cnt;
  logic            in_acc, out_free, out_valid_next;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // The output register loads from the done state, else it holds only while stalled.
  assign out_valid_next = ((state == S_DONE) && out_free) ? 1'b1 : (out_valid && out_stall);

  // Item registers.
  logic [31:0]        m, ax, d;
  logic               side, x_neg, set_ok, rd_bin_kind, rd_ok;
  logic [1:0]         region, set;
  logic [63:0]        mm_full, xm, xx, bprod, xxh, xxl;
  acc_t               inc_mm, inc_sxm, inc_xxm;
  logic [BinW-1:0]    bin;
  acc_t               res_data;
  logic [1:0]         res_region;
  logic [5:0]         res_bin;

  // RAM ports.
  logic              bin_we, st_we;
  logic [BinAw-1:0]  bin_waddr, bin_raddr;
  logic [StatAw-1:0] st_waddr, st_raddr;
  logic [63:0]       bin_wdata, st_wdata, bin_rdata, st_rdata;

  wha_ram #(.WIDTH(64), .DEPTH(BinDepth), .AW(BinAw)) u_bin_ram (
    .clk(clk), .we(bin_we), .waddr(bin_waddr), .wdata(bin_wdata),
    .raddr(bin_raddr), .rdata(bin_rdata)
  );

  wha_ram #(.WIDTH(64), .DEPTH(StatDepth), .AW(StatAw)) u_stat_ram (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  // Accept-time decode of a fill.
  logic signed [31:0] lo, hi;
  logic [32:0]        d_full;
  logic [1:0]         region_in;

  assign lo     = $signed(range_low);
  assign hi     = $signed(range_high);
  assign d_full = {sample_value[31], sample_value} - {lo[31], lo};

  always_comb begin
    if (sample_value < lo) begin
      region_in = REGION_UNDER;
    end else if (sample_value >= hi) begin
      region_in = REGION_OVER;
    end else begin
      region_in = REGION_IN;
    end
  end

  // Statistics word being written back during the update sweep.
  logic [2:0] wkind;
  acc_t       inc;
  logic [31:0] bin_hi32;

  assign wkind    = 3'(cnt - ClrW'(1));
  assign bin_hi32 = bprod[63:32];

  always_comb begin
    case (wkind)
      KIND_COUNT:  inc = 64'sd1;
      KIND_SUMW:   inc = acc_t'({32'd0, m});
      KIND_SUMWW:  inc = inc_mm;
      KIND_SUMXW:  inc = inc_sxm;
      KIND_SUMXXW: inc = inc_xxm;
      KIND_UNDER:  inc = (region == REGION_UNDER) ? acc_t'({32'd0, m}) : 64'sd0;
      KIND_OVER:   inc = (region == REGION_OVER) ? acc_t'({32'd0, m}) : 64'sd0;
      default:     inc = 64'sd0;
    endcase
  end

  always_comb begin
    bin_we    = 1'b0;
    st_we     = 1'b0;
    bin_waddr = BinAw'(((int'(bin) * NUM_WEIGHT_SETS + int'(set)) * 2) + int'(side));
    st_waddr  = StatAw'(((int'(wkind) * NUM_WEIGHT_SETS + int'(set)) * 2) + int'(side));
    bin_wdata = sat_add(acc_t'(bin_rdata), acc_t'({32'd0, m}));
    st_wdata  = sat_add(acc_t'(st_rdata), inc);
    bin_raddr = BinAw'(((int'(read_bin) * NUM_WEIGHT_SETS + int'(weight_set)) * 2)
                       + int'(read_negative_side));
    st_raddr  = StatAw'(((int'(read_kind) * NUM_WEIGHT_SETS + int'(weight_set)) * 2)
                        + int'(read_negative_side));
    unique case (state)
      S_CLEAR: begin
        bin_waddr = BinAw'(cnt);
        st_waddr  = StatAw'(cnt);
        bin_wdata = 64'd0;
        st_wdata  = 64'd0;
        bin_we    = (int'(cnt) < BinDepth);
        st_we     = (int'(cnt) < StatDepth);
      end
      S_UPD: begin
        bin_raddr = BinAw'(((int'(bin) * NUM_WEIGHT_SETS + int'(set)) * 2) + int'(side));
        st_raddr  = StatAw'(((int'(cnt) * NUM_WEIGHT_SETS + int'(set)) * 2) + int'(side));
        st_we     = set_ok && (cnt != '0);
        bin_we    = set_ok && (cnt == ClrW'(1)) && (region == REGION_IN);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      unique case (state)
        S_CLEAR: begin
          cnt <= cnt + ClrW'(1);
          if (int'(cnt) == ClrDepth - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          cnt <= '0;
          if (in_acc) begin
            state <= (cmd == CMD_READ) ? S_RD : S_MUL1;
          end
        end
        S_MUL1: state <= S_MUL2;
        S_MUL2: state <= S_MUL3;
        S_MUL3: state <= S_UPD;
        S_UPD: begin
          cnt <= cnt + ClrW'(1);
          if (cnt == ClrW'(KindCount)) begin
            state <= S_DONE;
          end
        end
        S_RD: state <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_neg       <= sample_value[31];
      side        <= sample_weight[31];
      m           <= sample_weight[31] ? 32'(-sample_weight) : sample_weight;
      ax          <= sample_value[31] ? 32'(-sample_value) : sample_value;
      d           <= d_full[31:0];
      region      <= region_in;
      set         <= weight_set;
      set_ok      <= (int'(weight_set) < NUM_WEIGHT_SETS);
      rd_bin_kind <= (read_kind == KIND_BIN);
      rd_ok       <= (int'(weight_set) < NUM_WEIGHT_SETS)
                     && ((read_kind != KIND_BIN) || (int'(read_bin) < NUM_BINS));
    end
    if (state == S_MUL1) begin
      mm_full <= 64'(m) * 64'(m);
      xm      <= 64'(ax) * 64'(m);
      xx      <= 64'(ax) * 64'(ax);
      bprod   <= 64'(d) * 64'(inverse_bin_width);
    end
    if (state == S_MUL2) begin
      xxh     <= 64'(xx[63:32]) * 64'(m);
      xxl     <= 64'(xx[31:0]) * 64'(m);
      inc_mm  <= acc_t'(mm_full >> 16);
      inc_sxm <= x_neg ? -acc_t'((xm + 64'hFFFF) >> 16) : acc_t'(xm >> 16);
      if (region != REGION_IN) begin
        bin <= '0;
      end else if (bin_hi32 > 32'(NUM_BINS - 1)) begin
        bin <= BinW'(NUM_BINS - 1);
      end else begin
        bin <= BinW'(bin_hi32);
      end
    end
    if (state == S_MUL3) begin
      inc_xxm    <= acc_t'(xxh + {32'd0, xxl[63:32]});
      res_data   <= 64'sd0;
      res_region <= region;
      res_bin    <= 6'(32'(bin));
    end
    if (state == S_RD) begin
      res_region <= REGION_READ;
      res_bin    <= 6'd0;
      if (!rd_ok) begin
        res_data <= 64'sd0;
      end else begin
        res_data <= rd_bin_kind ? acc_t'(bin_rdata) : acc_t'(st_rdata);
      end
    end
    if (state == S_DONE && out_free) begin
      read_data   <= res_data;
      fill_region <= res_region;
      fill_bin    <= res_bin;
    end
  end

`include "weighted_histogram_accumulator_defines.svh"

  `WHA_ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall, "accepted item did not block input")
  `WHA_ASSERT_NOW(a_fill_no_data, out_valid && fill_region != REGION_READ, read_data == 64'sd0, "fill result carries data")
  `WHA_ASSERT_NOW(a_bin_zero, out_valid && fill_region != REGION_IN, fill_bin == 6'd0, "bin reported outside range")
  `WHA_ASSERT_NOW(a_no_write_idle, state == S_IDLE, !bin_we && !st_we, "RAM written while idle")

endmodule

// ===== rtl/wha_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module wha_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== tb/sv/tb_weighted_histogram_accumulator.sv =====
// Testbench for the weighted histogram accumulator: directed and random fill and read beats.
// Depends on wha_pkg and the weighted_histogram_accumulator top level; self-checking.
module tb_weighted_histogram_accumulator;
  import wha_pkg::*;

  localparam int NBINS = 64;
  localparam int NSETS = 4;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic signed [63:0] data;
    logic [1:0]         region;
    logic [5:0]         bin;
  } hist_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic cmd = 1'b0;
  logic signed [31:0] sample_value = '0, sample_weight = '0;
  logic [1:0] weight_set = '0;
  logic [2:0] read_kind = '0;
  logic [5:0] read_bin = '0;
  logic read_negative_side = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [63:0] read_data;
  logic [1:0] fill_region;
  logic [5:0] fill_bin;

  weighted_histogram_accumulator dut (.*);

  always #2 clk = ~clk;

  // Shadow copy of the block's state and registers.
  acc_t bin_acc [NBINS*NSETS*2];
  acc_t stat_acc [KindCount*NSETS*2];
  logic signed [31:0] lo_edge, hi_edge;
  logic [31:0] inv_width;

  hist_result_t pending_results[$];
  int errors = 0;
  int idle_cycles = 0;
  bit long_hold = 1'b0;
  bit gaps_on = 1'b1;

  function automatic acc_t clamp_add(acc_t a, acc_t b);
    acc_t s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s;
  endfunction

  function automatic hist_result_t predict_hist(logic c, logic signed [31:0] x,
      logic signed [31:0] w, logic [1:0] ws, logic [2:0] kind, logic [5:0] rb, logic rs);
    hist_result_t r;
    logic side;
    logic [63:0] m, ax, mm, xm, xx, xxm, d, b;
    acc_t sxm;
    int si;
    r = '0;
    if (c == CMD_READ) begin
      r.region = REGION_READ;
      if (kind == KIND_BIN) r.data = bin_acc[(rb*NSETS + ws)*2 + rs];
      else r.data = stat_acc[(kind*NSETS + ws)*2 + rs];
      return r;
    end
    side = w[31];
    m = w[31] ? -64'(w) : 64'(w);
    ax = x[31] ? -64'(x) : 64'(x);
    mm = (m * m) >> 16;
    xm = ax * m;
    xx = ax * ax;
    xxm = (xx >> 32) * m + (((xx & 64'hFFFF_FFFF) * m) >> 32);
    sxm = x[31] ? -acc_t'((xm + 64'hFFFF) >> 16) : acc_t'(xm >> 16);
    if (x < lo_edge) r.region = REGION_UNDER;
    else if (x >= hi_edge) r.region = REGION_OVER;
    else begin
      d = 64'(64'sd0 + x - lo_edge);
      b = (d * 64'(inv_width)) >> 32;
      if (b > 64'(NBINS-1)) b = 64'(NBINS-1);
      r.bin = b[5:0];
      r.region = REGION_IN;
    end
    si = ws*2 + side;
    stat_acc[0*NSETS*2 + si] = clamp_add(stat_acc[0*NSETS*2 + si], 64'sd1);
    stat_acc[1*NSETS*2 + si] = clamp_add(stat_acc[1*NSETS*2 + si], acc_t'(m));
    stat_acc[2*NSETS*2 + si] = clamp_add(stat_acc[2*NSETS*2 + si], acc_t'(mm));
    stat_acc[3*NSETS*2 + si] = clamp_add(stat_acc[3*NSETS*2 + si], sxm);
    stat_acc[4*NSETS*2 + si] = clamp_add(stat_acc[4*NSETS*2 + si], acc_t'(xxm));
    if (r.region == REGION_UNDER)
      stat_acc[5*NSETS*2 + si] = clamp_add(stat_acc[5*NSETS*2 + si], acc_t'(m));
    else if (r.region == REGION_OVER)
      stat_acc[6*NSETS*2 + si] = clamp_add(stat_acc[6*NSETS*2 + si], acc_t'(m));
    else
      bin_acc[(r.bin*NSETS + ws)*2 + side] =
        clamp_add(bin_acc[(r.bin*NSETS + ws)*2 + side], acc_t'(m));
    return r;
  endfunction

  // Sends one beat; the expectation is formed at acceptance. Valid stays high
  // after the beat so that back-to-back beats follow without a gap.
  task automatic send_item(logic c, logic signed [31:0] x, logic signed [31:0] w,
      logic [1:0] ws, logic [2:0] kind, logic [5:0] rb, logic rs);
    int gap;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c; sample_value <= x; sample_weight <= w; weight_set <= ws;
    read_kind <= kind; read_bin <= rb; read_negative_side <= rs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_hist(c, x, w, ws, kind, rb, rs));
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_RANGE_LOW:  lo_edge = val;
      REG_RANGE_HIGH: hi_edge = val;
      default:        inv_width = val;
    endcase
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_range(logic [31:0] l, logic [31:0] h, logic [31:0] iw);
    drain_results();
    write_reg(REG_RANGE_LOW, l);
    write_reg(REG_RANGE_HIGH, h);
    write_reg(REG_INV_WIDTH, iw);
  endtask

  task automatic read_all(logic [1:0] ws);
    for (int k = 0; k < 8; k++)
      send_item(CMD_READ, $urandom, $urandom, ws, 3'(k), 6'($urandom), k[0]);
  endtask

  task automatic test_directed();
    send_item(CMD_FILL, 32'sd0, 32'sd0, 2'd0, KIND_COUNT, 6'd0, 1'b0);
    send_item(CMD_FILL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 2'd1, KIND_BIN, 6'd63, 1'b1);
    send_item(CMD_FILL, 32'h8000_0000, 32'h8000_0000, 2'd2, KIND_BIN, 6'd63, 1'b1);
    send_item(CMD_FILL, 32'h0003_FFFF, 32'hFFFF_0000, 2'd3, KIND_BIN, 6'd0, 1'b0);
    send_item(CMD_FILL, 32'h0001_8000, 32'h0002_0000, 2'd0, KIND_BIN, 6'd0, 1'b0);
    send_item(CMD_FILL, -32'sd1, 32'h0000_0001, 2'd0, KIND_BIN, 6'd0, 1'b0);
    send_item(CMD_FILL, 32'h0040_0000, 32'h0001_0000, 2'd0, KIND_BIN, 6'd0, 1'b0);
    for (int s = 0; s < NSETS; s++) read_all(2'(s));
    // Bin past the end and a zero inverse width.
    set_range(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_item(CMD_FILL, 32'h7FFF_FFFE, 32'h0001_0000, 2'd1, KIND_BIN, 6'd0, 1'b0);
    set_range(32'hFFFF_0000, 32'h0010_0000, 32'd0);
    send_item(CMD_FILL, 32'h0005_0000, 32'h0001_0000, 2'd1, KIND_BIN, 6'd0, 1'b0);
    // Empty range.
    set_range(32'h0010_0000, 32'h0010_0000, 32'h0001_0000);
    send_item(CMD_FILL, 32'h0010_0000, 32'h0001_0000, 2'd2, KIND_BIN, 6'd0, 1'b0);
    read_all(2'd1);
  endtask

  task automatic random_fill();
    logic signed [31:0] x;
    logic signed [31:0] w;
    case ($urandom_range(0, 3))
      0: x = $urandom;
      default: x = lo_edge + $signed(32'($urandom_range(0, 32'h0050_0000))) - 32'sh0008_0000;
    endcase
    case ($urandom_range(0, 4))
      0: w = $urandom;
      1: w = 32'($urandom_range(0, 3)) << 30;
      default: w = $signed(32'($urandom_range(0, 32'h0004_0000))) - 32'sh0002_0000;
    endcase
    send_item(CMD_FILL, x, w, 2'($urandom), 3'($urandom), 6'($urandom), 1'($urandom));
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_range(32'h0000_0000, 32'h0040_0000, 32'h0001_0000);
        1: set_range(32'hFFF0_0000, 32'h0010_0000, 32'h0000_2000);
        2: set_range($urandom, $urandom, $urandom);
        default: set_range(32'h0000_0000, 32'h0000_8000, 32'h0100_0000);
      endcase
      for (int i = 0; i < 400; i++) begin
        if ($urandom_range(0, 3) == 0)
          send_item(CMD_READ, $urandom, $urandom, 2'($urandom), 3'($urandom),
                    6'($urandom), 1'($urandom));
        else random_fill();
      end
    end
  endtask

  // Long receiver hold while the sender keeps going, so the block backs up.
  task automatic test_backpressure();
    gaps_on = 1'b0;
    long_hold = 1'b1;
    for (int i = 0; i < 30; i++) random_fill();
    gaps_on = 1'b1;
  endtask

  always @(posedge clk) begin
    if (long_hold) begin
      out_stall <= 1'b1;
      repeat (300) @(posedge clk);
      long_hold <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 15) < 5) && ($urandom_range(0, 99) > 20);
    end
  end

  always @(posedge clk) begin
    hist_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no expectation");
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (read_data !== e.data) begin
          $error("read_data expected %0d actual %0d", e.data, read_data); errors++;
        end
        if (fill_region !== e.region) begin
          $error("fill_region expected %0d actual %0d", e.region, fill_region); errors++;
        end
        if (fill_bin !== e.bin) begin
          $error("fill_bin expected %0d actual %0d", e.bin, fill_bin); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_weighted_histogram_accumulator NOT OK");
      $finish;
    end
  end

  initial begin
    foreach (bin_acc[i]) bin_acc[i] = '0;
    foreach (stat_acc[i]) stat_acc[i] = '0;
    lo_edge = 32'sd0; hi_edge = 32'sd4194304; inv_width = 32'd65536;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_random();
    drain_results();
    if (errors == 0 && pending_results.size() == 0)
      $display("tb_weighted_histogram_accumulator OK");
    else
      $display("tb_weighted_histogram_accumulator NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/wha_pkg.sv
rtl/wha_ram.sv
rtl/weighted_histogram_accumulator.sv
tb/sv/tb_weighted_histogram_accumulator.sv
